// File: src/sqec_pkg.sv
// Package: shared types, character constants and helper functions for the quote classifier.
`default_nettype none
package sqec_pkg;

  // Character codes the classifier reacts to
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    CL_DQUOTE = 2'd0,
    CL_SQUOTE = 2'd1,
    CL_PAREN  = 2'd2,
    CL_BRACE  = 2'd3
  } closer_t;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_STRING = 2'd1,
    CLS_CONST  = 2'd2
  } char_class_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_word_t;

  typedef struct packed {
    char_class_t char_class;
    logic        stack_overflow;
  } out_word_t;

  // Command from the classifier to the closer stack
  typedef struct packed {
    logic    push;
    logic    pop;
    logic    clear;
    closer_t code;
  } stack_cmd_t;

  function automatic logic [7:0] closer_char(input closer_t code);
    logic [7:0] ch;
    unique case (code)
      CL_DQUOTE: ch = CH_DQUOTE;
      CL_SQUOTE: ch = CH_SQUOTE;
      CL_PAREN:  ch = CH_RPAREN;
      CL_BRACE:  ch = CH_RBRACE;
      default:   ch = CH_RBRACE;
    endcase
    return ch;
  endfunction

  function automatic char_class_t closer_style(input closer_t code);
    char_class_t cls;
    unique case (code)
      CL_DQUOTE: cls = CLS_STRING;
      CL_SQUOTE: cls = CLS_STRING;
      CL_PAREN:  cls = CLS_NONE;
      CL_BRACE:  cls = CLS_CONST;
      default:   cls = CLS_NONE;
    endcase
    return cls;
  endfunction

  function automatic logic is_word_byte(input logic [7:0] c);
    logic blank;
    logic delim;
    blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    delim = (c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_LPAREN) || (c == CH_RPAREN);
    return !(blank || delim);
  endfunction

endpackage
`default_nettype wire

// File: src/shell_quote_expansion_classifier.sv
// Top level: per-character shell quote and expansion classifier with input and result registers.
//
// Usage:
//   in_valid/in_ready carry one character word per accepted beat: char_code and
//   line_end (set on the last character of a line). out_valid/out_ready carry
//   one result word per character: char_class (0 none, 1 string, 2 constant)
//   and stack_overflow (a quote or expansion push was dropped, stack full).
//   A word accepted into the input register is classified and written to the
//   result register, which drives out_valid and out_data.
//   Throughput: one character per cycle while out_ready stays high; the
//   classification of a word against the closer stack top is a single
//   registered step, and the stack top and next entry sit in registers so
//   pushes and pops back to back need one memory port each way.
//   Stall: when out_ready is low the result register holds, then the input
//   register holds and in_ready drops; nothing is lost or repeated.
//   Reset (rst_n low, synchronous): both registers empty, stack count and all
//   line flags cleared. Line end clears the stack and line flags after its character.
`default_nettype none
module shell_quote_expansion_classifier #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire sqec_pkg::in_word_t   in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      sqec_pkg::out_word_t  out_data
);
  import sqec_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  // Input stage
  logic     in_v_r;
  logic     in_v_nxt;
  in_word_t in_r;

  // Result stage
  logic      out_v_r;
  out_word_t out_r;
  out_word_t out_nxt;

  // Line state
  logic context_r, context_nxt;
  logic comment_r, comment_nxt;
  logic dollar_r, dollar_nxt;
  logic varword_r, varword_nxt;

  logic             advance;
  logic             fire;
  logic             in_take;
  stack_cmd_t       cmd;
  logic [CNT_W-1:0] stk_count;
  closer_t          stk_top;

  // Classifier decision signals
  logic        stk_full;
  logic        stk_nonempty;
  logic        push_req;
  closer_t     push_code;
  logic        do_push;
  logic        do_pop;
  char_class_t cls;

  // Result register frees when empty or being taken; input register follows
  assign advance  = !out_v_r || out_ready;
  assign in_ready = !in_v_r || advance;
  assign in_take  = in_valid && in_ready;
  assign fire     = in_v_r && advance;
  assign in_v_nxt = in_take || (in_v_r && !advance);

  assign stk_full     = (stk_count == CNT_W'(STACK_DEPTH));
  assign stk_nonempty = (stk_count != '0);

  always_comb begin
    logic       done;
    logic [7:0] c;
    logic       le;
    done         = comment_r;
    c            = in_r.char_code;
    le           = in_r.line_end;
    cls          = CLS_NONE;
    push_req     = 1'b0;
    push_code    = CL_DQUOTE;
    do_pop       = 1'b0;
    context_nxt  = context_r;
    comment_nxt  = comment_r;
    dollar_nxt   = dollar_r;
    varword_nxt  = varword_r;

    // Character right after a '$': expansion opener or start of a bare word
    if (!done && dollar_r) begin
      dollar_nxt = 1'b0;
      if (c == CH_LPAREN || c == CH_LBRACE) begin
        push_req    = 1'b1;
        push_code   = (c == CH_LPAREN) ? CL_PAREN : CL_BRACE;
        cls         = CLS_CONST;
        context_nxt = 1'b1;
        done        = 1'b1;
      end else begin
        varword_nxt = 1'b1;
      end
    end

    // Inside a bare $word: word bytes stay constant, anything else ends it
    if (!done && varword_nxt) begin
      if (is_word_byte(c)) begin
        cls  = CLS_CONST;
        done = 1'b1;
      end else begin
        varword_nxt = 1'b0;
      end
    end

    if (!done) begin
      if (!context_r && c == CH_HASH) begin
        // Comment start: rest of the line is plain
        comment_nxt = 1'b1;
      end else if (stk_nonempty && c == closer_char(stk_top)) begin
        // Matching closer: pop it
        cls         = (closer_style(stk_top) == CLS_STRING) ? CLS_STRING : CLS_CONST;
        do_pop      = 1'b1;
        context_nxt = 1'b1;
      end else begin
        if (c == CH_DQUOTE) begin
          push_req  = 1'b1;
          push_code = CL_DQUOTE;
        end else if (c == CH_SQUOTE) begin
          push_req  = 1'b1;
          push_code = CL_SQUOTE;
        end else if (c == CH_DOLLAR && !le) begin
          dollar_nxt = 1'b1;
          cls        = CLS_CONST;
        end
        // A dropped push leaves the stack and its top style as they were
        context_nxt = stk_nonempty || (push_req && !stk_full);
        if (cls == CLS_NONE) begin
          if (push_req && !stk_full) begin
            cls = CLS_STRING;
          end else if (stk_nonempty) begin
            cls = closer_style(stk_top);
          end
        end
      end
    end

    do_push = push_req && !stk_full;

    // Drop all line state after the last character
    if (le) begin
      context_nxt = 1'b0;
      comment_nxt = 1'b0;
      dollar_nxt  = 1'b0;
      varword_nxt = 1'b0;
    end

    out_nxt.char_class     = cls;
    out_nxt.stack_overflow = push_req && stk_full;
  end

  assign cmd.push  = fire && do_push;
  assign cmd.pop   = fire && do_pop;
  assign cmd.clear = fire && in_r.line_end;
  assign cmd.code  = push_code;

  sqec_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .count (stk_count),
    .top   (stk_top)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      context_r <= 1'b0;
      comment_r <= 1'b0;
      dollar_r  <= 1'b0;
      varword_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
      if (advance) begin
        out_v_r <= in_v_r;
      end
      if (fire) begin
        context_r <= context_nxt;
        comment_r <= comment_nxt;
        dollar_r  <= dollar_nxt;
        varword_r <= varword_nxt;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: src/sqec_stack.sv
// Closer stack: top and next entry in registers, deeper entries in a one-read one-write memory.
`default_nettype none
module sqec_stack #(
  parameter int STACK_DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire sqec_pkg::stack_cmd_t               cmd,
  output      logic [$clog2(STACK_DEPTH+1)-1:0]   count,
  output      sqec_pkg::closer_t                  top
);
  import sqec_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);

  // mem[i] holds entry i for every i below count-1; the top lives in top_r
  closer_t mem [STACK_DEPTH];
  closer_t top_r;
  closer_t below_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] wr_pos;
  logic [CNT_W-1:0] rd_pos;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;

  assign wr_pos = cnt_r - CNT_W'(1);
  assign rd_pos = cnt_r - CNT_W'(3);
  assign wr_idx = wr_pos[IDX_W-1:0];
  assign rd_idx = rd_pos[IDX_W-1:0];

  always_comb begin
    priority if (cmd.clear) begin
      cnt_nxt = '0;
    end else if (cmd.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Spill the old top on push; refill the next entry from memory on pop
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (cnt_r != '0) begin
        mem[wr_idx] <= top_r;
      end
      top_r   <= cmd.code;
      below_r <= top_r;
    end else if (cmd.pop) begin
      top_r   <= below_r;
      below_r <= mem[rd_idx];
    end
  end

  assign count = cnt_r;
  assign top   = top_r;

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Testbench for the shell quote and expansion classifier: directed lines, stack overflow and random lines.
`timescale 1ns / 1ps

module tb_top;
  import sqec_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int MAX_DRAIN_CYCLES = 20000;

  typedef enum int {
    LINE_PLAIN,
    LINE_DEEP,
    LINE_NOISE
  } line_mode_t;

  // Drive every input to a known value from time zero.
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // Idle switches for the sender and the receiver.
  logic in_gap_on  = 1'b1;
  logic out_gap_on = 1'b1;

  int mismatch_count = 0;

  // Predicted class words, oldest first.
  out_word_t expected_classes[$];

  // Predictor copy of the classifier state.
  closer_t pred_closers [STACK_DEPTH];
  int      pred_depth     = 0;
  logic    pred_ctx_seen  = 1'b0;
  logic    pred_comment   = 1'b0;
  logic    pred_dollar    = 1'b0;
  logic    pred_var_word  = 1'b0;

  shell_quote_expansion_classifier #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // Byte that closes a given stack entry.
  function automatic logic [7:0] closing_byte(input closer_t code);
    logic [7:0] b;
    case (code)
      CL_DQUOTE: b = CH_DQUOTE;
      CL_SQUOTE: b = CH_SQUOTE;
      CL_PAREN:  b = CH_RPAREN;
      default:   b = CH_RBRACE;
    endcase
    return b;
  endfunction

  // Push onto the predicted stack; return 1 when the push is dropped.
  function automatic logic predict_push(input closer_t code);
    if (pred_depth < STACK_DEPTH) begin
      pred_closers[pred_depth] = code;
      pred_depth++;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Classify one character word and advance the predicted state.
  function automatic out_word_t classify_char(input in_word_t w);
    out_word_t   res;
    logic [7:0]  c;
    logic        le;
    logic        done;
    logic        ovf;
    logic        name_byte;
    char_class_t cls;
    closer_t     top;
    c    = w.char_code;
    le   = w.line_end;
    cls  = CLS_NONE;
    ovf  = 1'b0;
    done = pred_comment;
    // A word byte is anything but blanks, quotes and parentheses.
    name_byte = !((c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)) ||
                  (c == CH_DQUOTE) || (c == CH_SQUOTE) ||
                  (c == CH_LPAREN) || (c == CH_RPAREN));

    if (!done && pred_dollar) begin
      pred_dollar = 1'b0;
      if (c == CH_LPAREN || c == CH_LBRACE) begin
        ovf           = predict_push(c == CH_LPAREN ? CL_PAREN : CL_BRACE);
        cls           = CLS_CONST;
        pred_ctx_seen = 1'b1;
        done          = 1'b1;
      end else begin
        pred_var_word = 1'b1;
      end
    end

    if (!done && pred_var_word) begin
      if (name_byte) begin
        cls  = CLS_CONST;
        done = 1'b1;
      end else begin
        pred_var_word = 1'b0;
      end
    end

    if (!done) begin
      top = (pred_depth > 0) ? pred_closers[pred_depth-1] : CL_DQUOTE;
      if (!pred_ctx_seen && c == CH_HASH) begin
        pred_comment = 1'b1;
      end else if (pred_depth > 0 && c == closing_byte(top)) begin
        cls = (top == CL_DQUOTE || top == CL_SQUOTE) ? CLS_STRING : CLS_CONST;
        pred_depth--;
        pred_ctx_seen = 1'b1;
      end else begin
        if (c == CH_DQUOTE) begin
          ovf = predict_push(CL_DQUOTE);
        end else if (c == CH_SQUOTE) begin
          ovf = predict_push(CL_SQUOTE);
        end else if (c == CH_DOLLAR && !le) begin
          pred_dollar = 1'b1;
          cls         = CLS_CONST;
        end
        pred_ctx_seen = (pred_depth > 0);
        // Otherwise take the style of the stack top after any push.
        if (cls == CLS_NONE && pred_depth > 0) begin
          case (pred_closers[pred_depth-1])
            CL_DQUOTE, CL_SQUOTE: cls = CLS_STRING;
            CL_BRACE:             cls = CLS_CONST;
            default:              cls = CLS_NONE;
          endcase
        end
      end
    end

    // Line end wipes all line state after its character.
    if (le) begin
      pred_depth    = 0;
      pred_ctx_seen = 1'b0;
      pred_comment  = 1'b0;
      pred_dollar   = 1'b0;
      pred_var_word = 1'b0;
    end

    res.char_class     = cls;
    res.stack_overflow = ovf;
    return res;
  endfunction

  // Send one character word: idle at random, hold valid and payload until
  // accepted, then queue its predicted class.
  task automatic send_char(input logic [7:0] c, input logic le);
    in_word_t w;
    w.char_code = c;
    w.line_end  = le;
    while (in_gap_on && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    // in_ready read right after the edge is the value the edge sampled.
    do @(posedge clk); while (!in_ready);
    expected_classes.push_back(classify_char(w));
  endtask

  // Send a text as one line; its last character carries line_end.
  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], i == s.len() - 1);
    end
  endtask

  // Pick the next character of a random line; plain lines lean toward
  // closing what is open so that nesting goes somewhere, deep lines pile
  // up quotes to hit the stack limit, noise lines are raw bytes.
  function automatic logic [7:0] pick_char(input line_mode_t mode);
    int         r;
    logic [7:0] c;
    closer_t    top;
    r   = $urandom_range(0, 99);
    top = (pred_depth > 0) ? pred_closers[pred_depth-1] : CL_DQUOTE;
    c   = 8'($urandom_range(8'h61, 8'h7A));
    if (mode == LINE_NOISE) begin
      c = 8'($urandom_range(0, 255));
    end else if (mode == LINE_DEEP) begin
      if (r < 45) begin
        // Alternate quote kinds so the new quote never pops the top.
        c = (pred_depth > 0 && top == CL_DQUOTE) ? CH_SQUOTE : CH_DQUOTE;
      end else if (r < 55) begin
        c = CH_DOLLAR;
      end else if (r < 60) begin
        c = CH_LBRACE;
      end else if (r < 65) begin
        c = CH_LPAREN;
      end else if (r < 72 && pred_depth > 0) begin
        c = closing_byte(top);
      end
    end else begin
      if (r < 10) begin
        c = CH_DQUOTE;
      end else if (r < 16) begin
        c = CH_SQUOTE;
      end else if (r < 26) begin
        c = CH_DOLLAR;
      end else if (r < 31) begin
        c = CH_LPAREN;
      end else if (r < 36) begin
        c = CH_LBRACE;
      end else if (r < 50) begin
        c = (pred_depth > 0) ? closing_byte(top) : CH_RPAREN;
      end else if (r < 54) begin
        c = CH_HASH;
      end else if (r < 58) begin
        c = $urandom_range(0, 1) ? CH_RPAREN : CH_RBRACE;
      end else if (r < 68) begin
        c = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
      end else if (r >= 90) begin
        c = 8'($urandom_range(0, 255));
      end
    end
    return c;
  endfunction

  // Quotes, command and parameter expansions, and a '#' right after a
  // closer that must not open a comment.
  task automatic test_quotes_and_expansions();
    send_text("\"x\"");
    send_text("$(a)");
    send_text("${v}#");
  endtask

  // Bare dollar word, a real comment, a dollar alone at line end and the
  // extreme byte values.
  task automatic test_comment_and_dollar_edges();
    send_text("$v #z");
    send_text("$");
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  // Fill the stack, then ask for a quote push and a "$(" push on top.
  task automatic test_stack_overflow();
    for (int i = 0; i < STACK_DEPTH; i++) begin
      send_char((i % 2 == 0) ? CH_DQUOTE : CH_SQUOTE, 1'b0);
    end
    send_char(CH_DQUOTE, 1'b0);
    send_char(CH_DOLLAR, 1'b0);
    send_char(CH_LPAREN, 1'b0);
    send_char(CH_SQUOTE, 1'b1);
  endtask

  // Random whole lines until at least n_items characters went out.
  task automatic test_random_lines(input int n_items);
    int         sent;
    int         len;
    int         r;
    line_mode_t mode;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        mode = LINE_NOISE;
        len  = $urandom_range(1, 16);
      end else if (r < 35) begin
        mode = LINE_DEEP;
        len  = $urandom_range(18, 40);
      end else begin
        mode = LINE_PLAIN;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 40) : $urandom_range(1, 20);
      end
      for (int i = 0; i < len; i++) begin
        send_char(pick_char(mode), i == len - 1);
      end
      sent += len;
    end
  endtask

  // Run random lines back to back with both sides always ready.
  task automatic test_no_idle_burst(input int n_items);
    in_gap_on  = 1'b0;
    out_gap_on = 1'b0;
    test_random_lines(n_items);
    in_gap_on  = 1'b1;
    out_gap_on = 1'b1;
  endtask

  // Check every accepted result word against the oldest prediction, then
  // pick the receiver's ready for the next edge.
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_classes.size() == 0) begin
        $error("out_data: unexpected result word, actual %0h", out_data);
        mismatch_count++;
      end else begin
        want = expected_classes.pop_front();
        if (out_data.char_class !== want.char_class) begin
          $error("char_class: expected %0d, actual %0d",
                 want.char_class, out_data.char_class);
          mismatch_count++;
        end
        if (out_data.stack_overflow !== want.stack_overflow) begin
          $error("stack_overflow: expected %0d, actual %0d",
                 want.stack_overflow, out_data.stack_overflow);
          mismatch_count++;
        end
      end
    end
    out_ready <= out_gap_on ? ($urandom_range(0, 99) >= 36) : 1'b1;
  end

  initial begin
    int drain_cycles;
    drain_cycles = 0;
    // Hold reset once at the start, then release it.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_quotes_and_expansions();
    test_comment_and_dollar_edges();
    test_stack_overflow();
    test_random_lines(300);
    test_no_idle_burst(200);
    test_random_lines(300);

    // Drop valid after the last word and wait for the results to drain.
    in_valid <= 1'b0;
    while (expected_classes.size() != 0 && drain_cycles < MAX_DRAIN_CYCLES) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (expected_classes.size() != 0) begin
      $error("out_data: expected %0d more result words, actual none",
             expected_classes.size());
      mismatch_count++;
    end
    // Leave room for any stray word after the last expected one.
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
